/* rtl/lirg_pkg.sv */
// Shared types and constants for the linear interpolation resampler with gain.
`timescale 1ns / 1ps
`default_nettype none
package lirg_pkg;
	localparam int unsigned ONE_POS = 65536;

	typedef enum logic [1:0] {
		FMT_S16   = 2'd0,
		FMT_S32   = 2'd1,
		FMT_FLOAT = 2'd2,
		FMT_RSVD  = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_STEREO = 2'd1,
		REG_STEP   = 2'd2,
		REG_GAIN   = 2'd3
	} reg_idx_t;

	// Converted frame passed from front to back
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} frame_t;

	// Float word to signed 16-bit: clamp to +-1, times 32767, truncate
	function automatic logic signed [15:0] float_to_s16(input logic [31:0] w);
		logic [7:0]  ex;
		logic [22:0] man;
		logic [23:0] m;
		logic [38:0] prod;
		logic [7:0]  sh;
		logic [15:0] mag;
		ex = w[30:23];
		man = w[22:0];
		m = (ex != 8'd0) ? {1'b1, man} : {1'b0, man};
		prod = 39'(m) * 39'd32767;
		sh = (ex != 8'd0) ? 8'(8'd150 - ex) : 8'd149;
		if (ex == 8'hFF && man != 23'd0) begin
			mag = 16'd0;
		end else if (ex >= 8'd127) begin
			mag = 16'd32767;
		end else if (sh >= 8'd39) begin
			mag = 16'd0;
		end else begin
			mag = 16'(prod >> sh);
		end
		return w[31] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [15:0] to_s16(input logic [1:0] fmt,
			input logic [31:0] w);
		logic signed [15:0] r;
		case (fmt)
			FMT_FLOAT: r = float_to_s16(w);
			FMT_S32:   r = $signed(w[31:16]);
			default:   r = $signed(w[15:0]);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/lirg_front.sv */
// Front part: accepts raw frames, converts samples, registers the frame.
`timescale 1ns / 1ps
`default_nettype none
module lirg_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      fmt,
	input  wire logic            stereo,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [31:0]     left_word,
	input  wire logic [31:0]     right_word,
	input  wire logic            buffer_end,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output lirg_pkg::frame_t     q_frame
);
	logic signed [15:0] nl, nr;

	assign nl = lirg_pkg::to_s16(fmt, left_word);
	assign nr = stereo ? lirg_pkg::to_s16(fmt, right_word) : nl;
	assign in_ready = !q_valid || q_ready;

	// Single slot holding one converted frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (in_ready) begin
			q_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			q_frame.left <= nl;
			q_frame.right <= nr;
			q_frame.last <= buffer_end;
		end
	end
endmodule
`default_nettype wire

/* rtl/lirg_queue.sv */
// Two-entry queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lirg_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	input  wire lirg_pkg::frame_t wr_data,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output lirg_pkg::frame_t     rd_data
);
	lirg_pkg::frame_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

/* rtl/lirg_back.sv */
// Back part: walks the phase over held frames, interpolates, applies gain.
`timescale 1ns / 1ps
`default_nettype none
module lirg_back #(
	parameter int MAX_RUN = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            stereo,
	input  wire logic [18:0]     step_ratio,
	input  wire logic [15:0]     gain,
	input  wire logic            f_valid,
	output logic                 f_ready,
	input  wire lirg_pkg::frame_t f_data,
	output logic                 m_valid,
	input  wire logic            m_ready,
	output logic signed [15:0]   out_left,
	output logic signed [15:0]   out_right,
	output logic                 run_last
);
	localparam int CW = $clog2(MAX_RUN + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_MIX, ST_GAIN, ST_END
	} state_t;

	state_t state_q;
	logic signed [15:0] held_l_q, held_r_q, a_l_q, a_r_q, b_l_q, b_r_q;
	logic signed [15:0] nxt_l_q, nxt_r_q;
	logic               held_valid_q, last_q, pass2_q;
	logic [21:0]        phase_q;
	logic [CW-1:0]      count_q;
	logic signed [15:0] s_l_q, s_r_q;
	logic               m_valid_q, pend_q;
	logic signed [15:0] o_l_q, o_r_q, p_l_q, p_r_q;
	logic               o_last_q, p_last_q;

	// Interpolation: a*(1-f)+b*f, truncated toward zero
	logic [16:0]        frac, inv;
	logic signed [34:0] mix_l, mix_r;
	logic signed [15:0] sl, sr;
	assign frac = {1'b0, phase_q[15:0]};
	assign inv = 17'(lirg_pkg::ONE_POS) - frac;
	assign mix_l = 35'(a_l_q * $signed({1'b0, inv})) + 35'(b_l_q * $signed({1'b0, frac}));
	assign mix_r = 35'(a_r_q * $signed({1'b0, inv})) + 35'(b_r_q * $signed({1'b0, frac}));
	function automatic logic signed [15:0] tdiv16(input logic signed [34:0] v);
		logic signed [34:0] t;
		t = v + ((v < 0) ? 35'sd65535 : 35'sd0);
		return 16'(t >>> 16);
	endfunction
	assign sl = tdiv16(mix_l);
	assign sr = tdiv16(mix_r);

	// Gain stage: s*gain/32768, truncated, saturated
	function automatic logic signed [15:0] gsat(input logic signed [15:0] s,
			input logic [15:0] g);
		logic signed [32:0] p, t;
		p = 33'(s * $signed({1'b0, g}));
		t = (p + ((p < 0) ? 33'sd32767 : 33'sd0)) >>> 15;
		if (t > 33'sd32767) return 16'sh7FFF;
		if (t < -33'sd32768) return 16'sh8000;
		return 16'(t);
	endfunction

	// One result register plus a skid slot
	logic out_free;
	assign out_free = !pend_q;
	assign m_valid = m_valid_q;
	assign out_left = o_l_q;
	assign out_right = o_r_q;
	assign f_ready = state_q == ST_IDLE;

	logic [22:0] ph_end;
	logic        more;
	assign more = ((count_q + 1'b1) < CW'(MAX_RUN)) &&
		((23'(phase_q) + 23'(step_ratio)) < 23'(lirg_pkg::ONE_POS));
	assign ph_end = 23'(phase_q) + 23'(step_ratio);

	logic last_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_valid_q <= 1'b0;
			phase_q <= 22'd0;
			count_q <= '0;
			m_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			// Drain output / skid; the gain state refills the output itself
			if (m_valid_q && m_ready) begin
				if (pend_q) begin
					o_l_q <= p_l_q;
					o_r_q <= p_r_q;
					o_last_q <= p_last_q;
					pend_q <= 1'b0;
				end else if (state_q != ST_GAIN) begin
					m_valid_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (f_valid) begin
						nxt_l_q <= f_data.left;
						nxt_r_q <= f_data.right;
						last_q <= f_data.last;
						count_q <= '0;
						a_l_q <= held_valid_q ? held_l_q : f_data.left;
						a_r_q <= held_valid_q ? held_r_q : f_data.right;
						b_l_q <= f_data.left;
						b_r_q <= f_data.right;
						pass2_q <= !held_valid_q;
						if (held_valid_q || f_data.last) begin
							state_q <= ST_CHECK;
						end else begin
							held_l_q <= f_data.left;
							held_r_q <= f_data.right;
							held_valid_q <= 1'b1;
						end
					end
				end
				ST_CHECK: begin
					if (count_q < CW'(MAX_RUN) && phase_q < 22'(lirg_pkg::ONE_POS)) begin
						state_q <= ST_MIX;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_MIX: begin
					s_l_q <= sl;
					s_r_q <= stereo ? sr : sl;
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (out_free) begin
						if (!m_valid_q || m_ready) begin
							o_l_q <= gsat(s_l_q, gain);
							o_r_q <= gsat(s_r_q, gain);
							o_last_q <= last_res;
							m_valid_q <= 1'b1;
						end else begin
							p_l_q <= gsat(s_l_q, gain);
							p_r_q <= gsat(s_r_q, gain);
							p_last_q <= last_res;
							pend_q <= 1'b1;
						end
						count_q <= count_q + 1'b1;
						phase_q <= 22'(ph_end);
						state_q <= more ? ST_MIX : ST_END;
					end
				end
				ST_END: begin
					phase_q <= (phase_q < 22'(lirg_pkg::ONE_POS)) ? 22'd0
						: 22'(phase_q - 22'(lirg_pkg::ONE_POS));
					if (!pass2_q && last_q) begin
						a_l_q <= nxt_l_q;
						a_r_q <= nxt_r_q;
						b_l_q <= nxt_l_q;
						b_r_q <= nxt_r_q;
						pass2_q <= 1'b1;
						state_q <= ST_CHECK;
					end else begin
						held_l_q <= nxt_l_q;
						held_r_q <= nxt_r_q;
						held_valid_q <= !last_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result is last of its item when no further one follows in this frame
	// and no second pass (buffer end) will yield results.
	logic second_yields;
	logic [22:0] nph;
	assign nph = ph_end - 23'(lirg_pkg::ONE_POS);
	assign second_yields = !pass2_q && last_q && (count_q + 1'b1) < CW'(MAX_RUN) &&
		(more || ph_end < 23'(lirg_pkg::ONE_POS) ||
		 nph < 23'(lirg_pkg::ONE_POS));
	assign last_res = !more && !second_yields;
	assign run_last = o_last_q;
endmodule
`default_nettype wire

/* rtl/linear_interp_resampler_gain_unit.sv */
// Top level: linear interpolation resampler with gain.
// The item completing a frame passes the front slot and queue; the back sequencer then
// steps IDLE, CHECK, MIX, GAIN to its first result. Per result MIX and GAIN run, per item
// IDLE, CHECK, END (CHECK/END again for a buffer end); a frame with nothing held is latched.
// Reset: asynchronous, clears held frame, phase, queue and registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module linear_interp_resampler_gain_unit #(
	parameter int MAX_RUN = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [18:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // left_word, right_word
	input  wire logic        s_tlast,   // buffer_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // out_left, out_right
	output logic             m_tlast    // run_last
);
	logic [1:0]  fmt_q;
	logic        stereo_q;
	logic [18:0] step_q;
	logic [15:0] gain_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= lirg_pkg::FMT_S16;
			stereo_q <= 1'b1;
			step_q <= 19'd60211;
			gain_q <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lirg_pkg::REG_FORMAT: fmt_q <= cfg_data[1:0];
				lirg_pkg::REG_STEREO: stereo_q <= cfg_data[0];
				lirg_pkg::REG_STEP:   step_q <= cfg_data;
				lirg_pkg::REG_GAIN:   gain_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic             fv, fr, qv, qr;
	lirg_pkg::frame_t fd, qd;
	logic signed [15:0] ol, orr;

	lirg_front u_front (
		.clk, .arst_n, .fmt(fmt_q), .stereo(stereo_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.left_word(s_tdata[31:0]), .right_word(s_tdata[63:32]), .buffer_end(s_tlast),
		.q_valid(fv), .q_ready(fr), .q_frame(fd)
	);

	lirg_queue u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qd)
	);

	lirg_back #(.MAX_RUN(MAX_RUN)) u_back (
		.clk, .arst_n, .stereo(stereo_q), .step_ratio(step_q), .gain(gain_q),
		.f_valid(qv), .f_ready(qr), .f_data(qd),
		.m_valid(m_tvalid), .m_ready(m_tready),
		.out_left(ol), .out_right(orr), .run_last(m_tlast)
	);

	assign m_tdata = {orr, ol};
endmodule
`default_nettype wire
